[rtl/domain_name_label_hash_core_assert.svh]
// Assertion macros for the domain name label hash core.
// Used by the top level only; expects a clock and an active-low reset.
`ifndef DOMAIN_NAME_LABEL_HASH_CORE_ASSERT_SVH
`define DOMAIN_NAME_LABEL_HASH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define DNLH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DNLH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dnlh_pkg.sv]
// Shared types, constants and byte folding for the domain name label hash core.
// No dependencies.
`timescale 1ns / 1ps

package dnlh_pkg;

	localparam int CHAR_W          = 8;
	localparam int HASH_W          = 32;
	localparam int LABEL_LIMIT_DEF = 65;

	// Special name bytes
	localparam logic [CHAR_W-1:0] CHAR_END       = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_DOT       = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

	// One finished name result
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              cut_short;
	} result_t;

	// Lower A-Z, then sign-extend to the hash width (signed char semantics)
	function automatic logic [HASH_W-1:0] fold_byte(input logic [CHAR_W-1:0] b);
		logic [CHAR_W-1:0] low;
		low = b;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
			low = b + CASE_OFFSET;
		return {{(HASH_W-CHAR_W){low[CHAR_W-1]}}, low};
	endfunction

	// hash * 31 as a shift and subtract, modulo 2^HASH_W
	function automatic logic [HASH_W-1:0] mul31(input logic [HASH_W-1:0] h);
		return (h << 5) - h;
	endfunction

endpackage

[rtl/domain_name_label_hash_core.sv]
// Domain name label hash core: input register, hasher and result register.
// Depends on dnlh_pkg, dnlh_hasher, dnlh_result_reg and the assertion header.
//
// Usage:
//   Input channel (in_valid / in_stall / character) carries one byte of an
//   escaped domain name per transfer; a zero byte ends the name. Output
//   channel (out_valid / out_stall / hash_value / cut_short) carries one
//   result per name, produced only for the zero byte.
//   Throughput: one byte per cycle while in_stall is low. Each byte is
//   registered, then updates the hash state (31*h + byte, a shift and subtract).
//   The zero byte's result then loads the output register and raises out_valid.
//   Stall: a result waiting in the output register does not block bytes of
//   the next name; only a second zero byte arriving while that result is
//   still stalled holds the input register and raises in_stall.
//   Reset: asynchronous, clears the hash state, input and output valid.
//   After each result the hash state returns to its reset value.
`timescale 1ns / 1ps
`include "domain_name_label_hash_core_assert.svh"

module domain_name_label_hash_core #(
	parameter int LABEL_LIMIT = dnlh_pkg::LABEL_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dnlh_pkg::CHAR_W-1:0]   character,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dnlh_pkg::HASH_W-1:0]   hash_value,
	output logic                          cut_short
);

	logic                        valid_s1;
	logic [dnlh_pkg::CHAR_W-1:0] char_s1;
	logic                        end_s1;
	logic                        go_s1;
	dnlh_pkg::result_t           result;

	// Stage 1 byte moves on unless it is an end byte and the result slot is busy
	assign end_s1   = char_s1 == dnlh_pkg::CHAR_END;
	assign go_s1    = valid_s1 && (!end_s1 || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			char_s1 <= character;
	end

	dnlh_hasher #(
		.LABEL_LIMIT(LABEL_LIMIT)
	) u_hasher (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (go_s1),
		.char_in (char_s1),
		.result  (result)
	);

	dnlh_result_reg u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (go_s1 && end_s1),
		.result     (result),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.cut_short  (cut_short)
	);

	// Checks
	`DNLH_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, valid_s1 && end_s1 && out_valid && out_stall, "input stalled without a blocked result")
	`DNLH_ASSERT_NEXT(a_end_makes_result, clk, arst_n, go_s1 && end_s1, out_valid, "end byte consumed but no result registered")
	`DNLH_ASSERT_SAME(a_result_has_cause, clk, arst_n, $rose(out_valid), $past(valid_s1 && end_s1), "result appeared without an end byte")

endmodule

[rtl/dnlh_hasher.sv]
// Per-byte hash state and update logic for the domain name label hash core.
// Depends on dnlh_pkg.
`timescale 1ns / 1ps

module dnlh_hasher #(
	parameter int LABEL_LIMIT = dnlh_pkg::LABEL_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [dnlh_pkg::CHAR_W-1:0]   char_in,
	output dnlh_pkg::result_t             result
);

	localparam int CNT_W = $clog2(LABEL_LIMIT);
	localparam logic [CNT_W:0] LIMIT_W = (CNT_W+1)'(LABEL_LIMIT);

	logic [dnlh_pkg::HASH_W-1:0] committed_hash_q, committed_hash_d;
	logic [dnlh_pkg::HASH_W-1:0] running_hash_q, running_hash_d;
	logic [CNT_W-1:0]            label_count_q, label_count_d;
	logic                        escape_pending_q, escape_pending_d;
	logic                        aborted_q, aborted_d;
	logic [CNT_W:0]              count_inc;
	logic [dnlh_pkg::HASH_W-1:0] hash_next;

	assign count_inc = {1'b0, label_count_q} + 1'b1;
	assign hash_next = dnlh_pkg::mul31(running_hash_q) + dnlh_pkg::fold_byte(char_in);

	// Result seen on the terminating byte: label closes unless aborted
	assign result.hash      = aborted_q ? committed_hash_q : running_hash_q;
	assign result.cut_short = aborted_q;

	// Next state for one consumed byte
	always_comb begin
		committed_hash_d = committed_hash_q;
		running_hash_d   = running_hash_q;
		label_count_d    = label_count_q;
		escape_pending_d = escape_pending_q;
		aborted_d        = aborted_q;
		if (step_en) begin
			if (char_in == dnlh_pkg::CHAR_END) begin
				committed_hash_d = '0;
				running_hash_d   = '0;
				label_count_d    = '0;
				escape_pending_d = 1'b0;
				aborted_d        = 1'b0;
			end else if (aborted_q) begin
				// ignore everything until the end byte
			end else if (!escape_pending_q && char_in == dnlh_pkg::CHAR_BACKSLASH) begin
				escape_pending_d = 1'b1;
			end else if (!escape_pending_q && char_in == dnlh_pkg::CHAR_DOT) begin
				committed_hash_d = running_hash_q;
				label_count_d    = '0;
			end else begin
				escape_pending_d = 1'b0;
				if (count_inc >= LIMIT_W) begin
					// overlong label: drop it and freeze
					aborted_d      = 1'b1;
					running_hash_d = committed_hash_q;
					label_count_d  = '0;
				end else begin
					running_hash_d = hash_next;
					label_count_d  = count_inc[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_hash_q <= '0;
			running_hash_q   <= '0;
			label_count_q    <= '0;
			escape_pending_q <= 1'b0;
			aborted_q        <= 1'b0;
		end else begin
			committed_hash_q <= committed_hash_d;
			running_hash_q   <= running_hash_d;
			label_count_q    <= label_count_d;
			escape_pending_q <= escape_pending_d;
			aborted_q        <= aborted_d;
		end
	end

endmodule

[rtl/dnlh_result_reg.sv]
// Output register for finished hash results, held while the receiver stalls.
// Depends on dnlh_pkg.
`timescale 1ns / 1ps

module dnlh_result_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  dnlh_pkg::result_t             result,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dnlh_pkg::HASH_W-1:0]   hash_value,
	output logic                          cut_short
);

	logic                        valid_q;
	logic [dnlh_pkg::HASH_W-1:0] hash_q;
	logic                        cut_q;

	assign out_valid  = valid_q;
	assign hash_value = hash_q;
	assign cut_short  = cut_q;

	// Valid holds until the transfer completes or a new result loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hash_q <= result.hash;
			cut_q  <= result.cut_short;
		end
	end

endmodule

[tb/domain_name_label_hash_core_tb.sv]
// Self-checking testbench for domain_name_label_hash_core: name bytes in, label hashes out.
// Depends on dnlh_pkg and the core; keeps its own hash state to predict each result.
`timescale 1ns / 1ps

module domain_name_label_hash_core_tb;

	typedef logic [dnlh_pkg::CHAR_W-1:0] char_t;

	localparam int HASH_MULT    = 31;
	localparam int NAME_LIMIT   = dnlh_pkg::LABEL_LIMIT_DEF;
	localparam int MAX_IDLE     = 5;
	localparam int RANDOM_BYTES = 700;
	localparam int RANDOM_NAMES = 40;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	char_t                         character = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [dnlh_pkg::HASH_W-1:0]   hash_value;
	logic                          cut_short;

	// Predicted hash state
	logic [dnlh_pkg::HASH_W-1:0]   done_hash;
	logic [dnlh_pkg::HASH_W-1:0]   label_hash;
	logic [8:0]                    label_len;
	logic                          escape_armed;
	logic                          overlong;

	dnlh_pkg::result_t   pending_hashes[$];
	int                  errors = 0;
	int                  cycle_count = 0;
	int                  bytes_sent = 0;
	int                  names_sent = 0;

	// Idle control for both sides
	bit                  tx_idle_on = 1'b1;
	bit                  rx_idle_on = 1'b1;
	bit                  rx_full_stall = 1'b0;
	int                  stall_left = 0;

	domain_name_label_hash_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.cut_short  (cut_short)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Lower A-Z, sign-extend bytes 128-255
	function automatic logic [dnlh_pkg::HASH_W-1:0] fold_char(input char_t c);
		char_t lc;
		lc = c;
		if (c >= dnlh_pkg::CHAR_UPPER_A && c <= dnlh_pkg::CHAR_UPPER_Z)
			lc = c | dnlh_pkg::CASE_OFFSET;
		return {{(dnlh_pkg::HASH_W-dnlh_pkg::CHAR_W){lc[dnlh_pkg::CHAR_W-1]}}, lc};
	endfunction

	function automatic void clear_name_state();
		done_hash    = '0;
		label_hash   = '0;
		label_len    = '0;
		escape_armed = 1'b0;
		overlong     = 1'b0;
	endfunction

	// Advance the predicted state by one accepted byte
	function automatic void hash_name_byte(input char_t c);
		dnlh_pkg::result_t r;
		if (c == dnlh_pkg::CHAR_END) begin
			if (!overlong)
				done_hash = label_hash;
			r.hash      = done_hash;
			r.cut_short = overlong;
			pending_hashes.push_back(r);
			clear_name_state();
			return;
		end
		if (overlong)
			return;
		if (!escape_armed && c == dnlh_pkg::CHAR_BACKSLASH) begin
			escape_armed = 1'b1;
			return;
		end
		if (!escape_armed && c == dnlh_pkg::CHAR_DOT) begin
			done_hash = label_hash;
			label_len = '0;
			return;
		end
		escape_armed = 1'b0;
		label_hash   = label_hash * HASH_MULT + fold_char(c);
		label_len    = label_len + 9'd1;
		if (label_len >= NAME_LIMIT) begin
			overlong   = 1'b1;
			label_hash = done_hash;
		end
	endfunction

	// Receiver stall: counts down only while a result is offered
	always @(negedge clk) begin
		out_stall <= (stall_left != 0);
		if (stall_left != 0 && out_valid)
			stall_left = stall_left - 1;
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		dnlh_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hashes.size() == 0) begin
				$error("result with none pending: hash_value=%h cut_short=%b",
					hash_value, cut_short);
				errors++;
			end else begin
				want = pending_hashes.pop_front();
				if (hash_value !== want.hash) begin
					$error("hash_value: expected %h, got %h", want.hash, hash_value);
					errors++;
				end
				if (cut_short !== want.cut_short) begin
					$error("cut_short: expected %b, got %b", want.cut_short, cut_short);
					errors++;
				end
			end
			if (rx_full_stall)
				stall_left = MAX_IDLE;
			else if (rx_idle_on)
				stall_left = $urandom_range(0, MAX_IDLE);
			else
				stall_left = 0;
		end
	end

	// One byte transfer; entered and left at a falling edge
	task automatic send_byte(input char_t c);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		repeat (gap) begin
			in_valid  <= 1'b0;
			character <= char_t'($urandom_range(0, 255));
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		hash_name_byte(c);
		bytes_sent++;
		if (c == dnlh_pkg::CHAR_END)
			names_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Sender holds off until every predicted result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_hashes.size() != 0);
	endtask

	task automatic test_empty_names();
		send_byte(dnlh_pkg::CHAR_END);
		send_text(".");
		send_byte(dnlh_pkg::CHAR_END);
		send_text(".a..b.");
		send_byte(dnlh_pkg::CHAR_END);
	endtask

	// Letters and their neighbors in the code table
	task automatic test_case_folding();
		send_text("AZ@[`{az");
		send_byte(dnlh_pkg::CHAR_END);
	endtask

	task automatic test_high_bytes();
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(dnlh_pkg::CHAR_END);
	endtask

	task automatic test_escapes();
		send_text("\\.\\\\x.y\\Q");
		send_byte(dnlh_pkg::CHAR_END);
		// backslash right before the end byte
		send_text("ab\\");
		send_byte(dnlh_pkg::CHAR_END);
	endtask

	task automatic test_overlong_label();
		// one byte under the limit, then a full-limit label after a good one
		repeat (NAME_LIMIT - 1) send_byte("x");
		send_text(".y");
		send_byte(dnlh_pkg::CHAR_END);
		send_text("ok.");
		repeat (NAME_LIMIT - 1) send_byte("k");
		send_text("\\.\\.z");
		send_byte(dnlh_pkg::CHAR_END);
	endtask

	// Back-to-back end bytes against a stalled result
	task automatic test_result_backpressure();
		tx_idle_on    = 1'b0;
		rx_full_stall = 1'b1;
		repeat (6) send_byte(dnlh_pkg::CHAR_END);
		send_text("q");
		send_byte(dnlh_pkg::CHAR_END);
		wait_for_results();
		rx_full_stall = 1'b0;
		tx_idle_on    = 1'b1;
	endtask

	function automatic char_t pick_label_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return char_t'("a" + $urandom_range(0, 25));
		if (r < 60) return char_t'("A" + $urandom_range(0, 25));
		if (r < 70) return char_t'("0" + $urandom_range(0, 9));
		return char_t'($urandom_range(1, 255));
	endfunction

	// Well-formed names with random content, plus raw noise
	task automatic test_random_names();
		char_t name_q[$];
		int labels, len, r;
		while (bytes_sent < RANDOM_BYTES || names_sent < RANDOM_NAMES) begin
			name_q.delete();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 9) == 0)
					name_q.push_back(dnlh_pkg::CHAR_DOT);
				labels = $urandom_range(1, 4);
				for (int l = 0; l < labels; l++) begin
					if (l != 0) begin
						name_q.push_back(dnlh_pkg::CHAR_DOT);
						if ($urandom_range(0, 11) == 0)
							name_q.push_back(dnlh_pkg::CHAR_DOT);
					end
					r = $urandom_range(0, 99);
					if (r < 82)      len = $urandom_range(0, 8);
					else if (r < 94) len = $urandom_range(9, 20);
					else             len = $urandom_range(NAME_LIMIT - 3, NAME_LIMIT + 4);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 9) == 0) begin
							name_q.push_back(dnlh_pkg::CHAR_BACKSLASH);
							r = $urandom_range(0, 2);
							if (r == 0)      name_q.push_back(dnlh_pkg::CHAR_DOT);
							else if (r == 1) name_q.push_back(dnlh_pkg::CHAR_BACKSLASH);
							else             name_q.push_back(char_t'($urandom_range(1, 255)));
						end else
							name_q.push_back(pick_label_char());
					end
				end
				if ($urandom_range(0, 4) == 0)
					name_q.push_back(dnlh_pkg::CHAR_DOT);
				if ($urandom_range(0, 19) == 0)
					name_q.push_back(dnlh_pkg::CHAR_BACKSLASH);
			end else begin
				// noise, may hold extra end bytes
				len = $urandom_range(0, 30);
				repeat (len) name_q.push_back(char_t'($urandom_range(0, 255)));
			end
			name_q.push_back(dnlh_pkg::CHAR_END);
			foreach (name_q[i])
				send_byte(name_q[i]);
			if ($urandom_range(0, 9) == 0)
				wait_for_results();
		end
	endtask

	initial begin
		clear_name_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_names();
		test_case_folding();
		test_high_bytes();
		test_escapes();
		wait_for_results();
		test_overlong_label();
		test_result_backpressure();
		test_random_names();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_hashes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/dnlh_pkg.sv
rtl/dnlh_hasher.sv
rtl/dnlh_result_reg.sv
rtl/domain_name_label_hash_core.sv
tb/domain_name_label_hash_core_tb.sv
